/* src/tkd_pkg.sv */
`timescale 1ns / 1ps
package tkd_pkg;
  localparam logic [13:0] KEY_BASE = 14'd10007;
  localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

  typedef enum logic [1:0] {
    REQ_OFFER = 2'd0,
    REQ_PROBE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_READ3 = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    OUT_INSERTED = 3'd0,
    OUT_BELOW    = 3'd1,
    OUT_DUP      = 3'd2,
    OUT_PROBENEW = 3'd3,
    OUT_FULL     = 3'd4,
    OUT_READ     = 3'd5
  } outcome_t;

  localparam logic [0:0] CFG_KEEP_LIMIT = 1'b0;
  localparam logic [0:0] CFG_TRACK      = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] target_value;
    logic [15:0] leader_card;
    logic [31:0] cand_score;
    logic [31:0] cand_live;
    logic [23:0] cand_power;
    logic [31:0] algo_mask;
    logic [5:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [6:0]  count_kept;
    logic [47:0] floor_value;
    logic [23:0] floor_strength;
    logic [31:0] sources;
    logic        entry_valid;
    logic [47:0] entry_target;
    logic [15:0] entry_card;
    logic [31:0] entry_score;
    logic [31:0] entry_live;
    logic [23:0] entry_power;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RANK, ST_RD0, ST_RD1, ST_K0, ST_K1, ST_K2, ST_K3, ST_K4, ST_K5,
    ST_H0, ST_H1, ST_H2, ST_PR0, ST_PR1, ST_PR2, ST_ACT, ST_SRCH, ST_SHIFT,
    ST_SHIFTW, ST_PLACE, ST_FLOOR0, ST_FLOOR1, ST_DONE
  } state_t;
endpackage

/* src/tkd_fifo.sv */
`timescale 1ns / 1ps
module tkd_fifo
  import tkd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_data,
  output logic  empty
);
  item_t mem [4];
  logic [2:0] wp, rp;

  assign full    = (wp - rp) == 3'd4;
  assign empty   = wp == rp;
  assign rd_data = mem[rp[1:0]];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem[wp[1:0]] <= wr_data;
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (wr_en && !full) wp <= wp + 3'd1;
      if (rd_en && !empty) rp <= rp + 3'd1;
    end
  end
endmodule

/* src/tkd_engine.sv */
`timescale 1ns / 1ps
module tkd_engine
  import tkd_pkg::*;
#(
  parameter int KEEP_MAX   = 64,
  parameter int SEEN_DEPTH = 4096,
  parameter int PROBE_MAX  = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic     cfg_idx,
  input  logic [6:0] cfg_data,
  input  logic     in_valid,
  input  item_t    in_item,
  output logic     in_take,
  output logic     res_valid,
  output result_t  res,
  input  logic     res_take,
  output logic     busy_clear
);
  localparam int KW = $clog2(KEEP_MAX + 1);
  localparam int KA = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
  localparam int SA = $clog2(SEEN_DEPTH);
  localparam int PW = $clog2(PROBE_MAX + 1);

  logic [6:0] keep_limit;
  logic       track_sources;

  logic [47:0] k_target [KEEP_MAX];
  logic [15:0] k_card   [KEEP_MAX];
  logic [31:0] k_score  [KEEP_MAX];
  logic [31:0] k_live   [KEEP_MAX];
  logic [23:0] k_power  [KEEP_MAX];

  logic [63:0] s_key [SEEN_DEPTH];
  logic [31:0] s_src [SEEN_DEPTH];
  logic        s_used [SEEN_DEPTH];

  state_t state, state_next;
  item_t  it;
  logic [KW-1:0] size;
  logic [KW-1:0] limit;
  logic [47:0] tfloor;
  logic [23:0] pfloor;
  logic [SA:0] clr;

  logic [KA-1:0] k_addr;
  logic [47:0] r_target;
  logic [15:0] r_card;
  logic [31:0] r_score, r_live;
  logic [23:0] r_power;

  logic [63:0] key, acc;
  logic [63:0] prod;
  logic [SA-1:0] slot;
  logic [PW-1:0] probe;
  logic [63:0] rd_key;
  logic [31:0] rd_src;
  logic        rd_used;
  logic [KW-1:0] pos;
  logic [KW-1:0] sh;
  logic [KW-1:0] grown;
  logic        is_read;
  result_t     out;
  logic [1:0]  found;

  logic [7:0] lim_c;
  assign lim_c = (keep_limit == 7'd0) ? 8'd1 :
                 ({1'b0, keep_limit} > 8'(KEEP_MAX)) ? 8'(KEEP_MAX) : {1'b0, keep_limit};
  assign limit = KW'(lim_c);

  // size after placing the new entry; unchanged when it falls off a full list
  assign grown = (size >= KW'(KEEP_MAX)) ? KW'(KEEP_MAX) : size + 1'b1;
  assign sh    = (pos >= KW'(KEEP_MAX)) ? size : (grown > limit) ? limit : grown;

  function automatic logic above(logic [47:0] ta, logic [15:0] ca,
                                 logic [47:0] tb, logic [15:0] cb);
    return ta > tb || (ta == tb && ca < cb);
  endfunction

  always_ff @(posedge clk) begin
    r_target <= k_target[k_addr];
    r_card   <= k_card[k_addr];
    r_score  <= k_score[k_addr];
    r_live   <= k_live[k_addr];
    r_power  <= k_power[k_addr];
    rd_key   <= s_key[slot];
    rd_src   <= s_src[slot];
    rd_used  <= s_used[slot];
  end

  assign busy_clear = !clr[SA];
  assign in_take    = (state == ST_IDLE) && in_valid && clr[SA];
  assign res_valid  = state == ST_DONE;
  assign res        = out;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_take) state_next = ST_RANK;
      ST_DONE:   if (res_take) state_next = ST_IDLE;
      default:   state_next = state;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      keep_limit <= 7'd64;
      track_sources <= 1'b0;
      size <= '0;
      tfloor <= '0;
      pfloor <= '0;
      clr <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_KEEP_LIMIT) keep_limit <= cfg_data;
        else track_sources <= cfg_data[0];
      end
      if (!clr[SA]) begin
        s_used[clr[SA-1:0]] <= 1'b0;
        clr <= clr + 1'b1;
      end
      case (state)
        ST_IDLE: if (in_take) begin
          it <= in_item;
          is_read <= in_item.req_type[1];
          out <= '0;
          found <= 2'd0;
          k_addr <= in_item.req_type[1] ? KA'(in_item.read_index) : KA'(size - 1'b1);
          state <= ST_RD0;
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          if (is_read) begin
            out.outcome <= OUT_READ;
            if ({1'b0, it.read_index} < 7'(size) && 32'(it.read_index) < KEEP_MAX) begin
              out.entry_valid  <= 1'b1;
              out.entry_target <= r_target;
              out.entry_card   <= r_card;
              out.entry_score  <= r_score;
              out.entry_live   <= r_live;
              out.entry_power  <= r_power;
              it.cand_score <= r_score;
              it.cand_live  <= r_live;
              it.cand_power <= r_power;
              it.leader_card <= r_card;
              acc <= 64'(r_score);
              state <= ST_K0;
            end else state <= ST_FLOOR1;
          end else if (size >= limit && above(r_target, r_card, it.target_value,
                                               it.leader_card)) begin
            out.outcome <= OUT_BELOW;
            state <= ST_FLOOR1;
          end else begin
            acc <= 64'(it.cand_score);
            state <= ST_K0;
          end
        end
        ST_K0: begin prod <= acc * 64'(KEY_BASE); state <= ST_K1; end
        ST_K1: begin acc <= prod + 64'(it.cand_live); state <= ST_K2; end
        ST_K2: begin prod <= acc * 64'(KEY_BASE); state <= ST_K3; end
        ST_K3: begin acc <= prod + 64'(it.cand_power); state <= ST_K4; end
        ST_K4: begin prod <= acc * 64'(KEY_BASE); state <= ST_K5; end
        ST_K5: begin key <= prod + 64'(it.leader_card); state <= ST_H0; end
        ST_H0: begin prod <= key[31:0] * HASH_MUL[31:0]; acc <= 64'(key[31:0] * HASH_MUL[63:32]);
          state <= ST_H1; end
        ST_H1: begin acc <= acc + 64'(key[63:32] * HASH_MUL[31:0]); state <= ST_H2; end
        ST_H2: begin
          slot <= SA'(acc[31:0] + prod[63:32]);
          probe <= '0;
          state <= ST_PR0;
        end
        ST_PR0: state <= ST_PR1;
        ST_PR1: begin
          if (!rd_used) begin found <= 2'd1; state <= ST_ACT; end
          else if (rd_key == key) begin found <= 2'd2; state <= ST_ACT; end
          else if (32'(probe) == PROBE_MAX - 1) begin found <= 2'd0; state <= ST_ACT; end
          else begin probe <= probe + 1'b1; slot <= slot + 1'b1; state <= ST_PR0; end
        end
        ST_ACT: begin
          state <= ST_FLOOR1;
          if (is_read) begin
            if (found == 2'd2) out.sources <= rd_src;
          end else if (found == 2'd0) out.outcome <= OUT_FULL;
          else if (found == 2'd2) begin
            out.outcome <= OUT_DUP;
            if (it.req_type == REQ_OFFER || track_sources) begin
              s_src[slot] <= rd_src | it.algo_mask;
              out.sources <= rd_src | it.algo_mask;
            end else out.sources <= rd_src;
          end else if (it.req_type == REQ_PROBE) out.outcome <= OUT_PROBENEW;
          else begin
            out.outcome <= OUT_INSERTED;
            out.sources <= it.algo_mask;
            s_used[slot] <= 1'b1;
            s_key[slot] <= key;
            s_src[slot] <= it.algo_mask;
            pos <= size;
            k_addr <= KA'(size - 1'b1);
            state <= (size == '0) ? ST_PLACE : ST_SHIFTW;
          end
        end
        ST_SHIFTW: state <= ST_SRCH;
        ST_SRCH: begin
          if (above(it.target_value, it.leader_card, r_target, r_card)) begin
            if (pos < KW'(KEEP_MAX)) begin
              k_target[KA'(pos)] <= r_target;
              k_card[KA'(pos)]   <= r_card;
              k_score[KA'(pos)]  <= r_score;
              k_live[KA'(pos)]   <= r_live;
              k_power[KA'(pos)]  <= r_power;
            end
            pos <= pos - 1'b1;
            if (pos == KW'(1)) state <= ST_PLACE;
            else begin k_addr <= KA'(pos - KW'(2)); state <= ST_SHIFTW; end
          end else state <= ST_PLACE;
        end
        ST_PLACE: begin
          if (pos < KW'(KEEP_MAX)) begin
            k_target[KA'(pos)] <= it.target_value;
            k_card[KA'(pos)]   <= it.leader_card;
            k_score[KA'(pos)]  <= it.cand_score;
            k_live[KA'(pos)]   <= it.cand_live;
            k_power[KA'(pos)]  <= it.cand_power;
            size <= sh;
          end
          if (sh >= limit) begin
            k_addr <= KA'(sh - 1'b1);
            state <= ST_FLOOR0;
          end else state <= ST_FLOOR1;
        end
        ST_FLOOR0: state <= ST_SHIFT;
        ST_SHIFT: begin
          if (r_target > tfloor) tfloor <= r_target;
          if (r_power > pfloor) pfloor <= r_power;
          state <= ST_FLOOR1;
        end
        ST_FLOOR1: begin
          out.count_kept     <= 7'(size);
          out.floor_value    <= tfloor;
          out.floor_strength <= pfloor;
          state <= ST_DONE;
        end
        ST_DONE: if (res_take) state <= state_next;
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

/* src/top_k_dedup_keeper.sv */
`timescale 1ns / 1ps
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | req_type .. read_index
// out     | out_valid| out_stall | outcome .. entry_power
// An item rejected below the worst entry skips the key build and the seen store;
// a read of a kept entry, a probe or an offer that inserts nothing goes through
// the key build, the hash, then up to PROBE_MAX seen-store probes. An insert
// also moves each kept entry that ranks below it down one place.
// After reset every seen-store slot is cleared before items are taken.
// A four-deep queue takes items while the engine works; results hold under stall.
module top_k_dedup_keeper
  import tkd_pkg::*;
#(
  parameter int KEEP_MAX   = 64,
  parameter int SEEN_DEPTH = 4096,
  parameter int PROBE_MAX  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [47:0] target_value,
  input  logic [15:0] leader_card,
  input  logic [31:0] cand_score,
  input  logic [31:0] cand_live,
  input  logic [23:0] cand_power,
  input  logic [31:0] algo_mask,
  input  logic [5:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  outcome,
  output logic [6:0]  count_kept,
  output logic [47:0] floor_value,
  output logic [23:0] floor_strength,
  output logic [31:0] sources,
  output logic        entry_valid,
  output logic [47:0] entry_target,
  output logic [15:0] entry_card,
  output logic [31:0] entry_score,
  output logic [31:0] entry_live,
  output logic [23:0] entry_power
);
  item_t   wr, rd;
  result_t r;
  logic full, empty, take, busy_clear;

  assign wr = '{req_type, target_value, leader_card, cand_score, cand_live,
                cand_power, algo_mask, read_index};
  assign in_stall = full;

  tkd_fifo u_q (.clk, .rst, .wr_en(in_valid), .wr_data(wr), .full,
                .rd_en(take), .rd_data(rd), .empty);

  tkd_engine #(.KEEP_MAX(KEEP_MAX), .SEEN_DEPTH(SEEN_DEPTH), .PROBE_MAX(PROBE_MAX)) u_eng (
    .clk, .rst, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .in_valid(!empty), .in_item(rd), .in_take(take),
    .res_valid(out_valid), .res(r), .res_take(!out_stall), .busy_clear);

  assign outcome        = r.outcome;
  assign count_kept     = r.count_kept;
  assign floor_value    = r.floor_value;
  assign floor_strength = r.floor_strength;
  assign sources        = r.sources;
  assign entry_valid    = r.entry_valid;
  assign entry_target   = r.entry_target;
  assign entry_card     = r.entry_card;
  assign entry_score    = r.entry_score;
  assign entry_live     = r.entry_live;
  assign entry_power    = r.entry_power;

  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    busy_clear |-> !take) else $error("item taken during clear");
  a_read_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_valid |-> outcome == OUT_READ) else $error("entry on non-read");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count_kept <= 7'(KEEP_MAX)) else $error("count overflow");
endmodule

/* verif/top_k_dedup_keeper_tb.sv */
`timescale 1ns / 1ps
module top_k_dedup_keeper_tb;
  import tkd_pkg::*;

  localparam int KEEP_N = 64;
  localparam int SEEN_N = 4096;
  localparam int PROBES = 8;
  localparam int WATCHDOG = 30000;

  function automatic logic [63:0] key_of(logic [31:0] s, logic [31:0] l, logic [23:0] p,
                                         logic [15:0] c);
    logic [63:0] k;
    k = {32'd0, s};
    k = k * 64'd10007 + l;
    k = k * 64'd10007 + p;
    k = k * 64'd10007 + c;
    return k;
  endfunction

  class keeper_scoreboard;
    logic [47:0] kt[KEEP_N];
    logic [15:0] kc[KEEP_N];
    logic [31:0] ks[KEEP_N];
    logic [31:0] kl[KEEP_N];
    logic [23:0] kp[KEEP_N];
    int          size;
    logic [63:0] skey[SEEN_N];
    bit          sused[SEEN_N];
    logic [31:0] ssrc[SEEN_N];
    logic [47:0] tfloor;
    logic [23:0] pfloor;
    int          limit_reg;
    bit          track;
    result_t     pending[$];
    int          errors;

    function new();
      size = 0;
      tfloor = '0;
      pfloor = '0;
      limit_reg = 64;
      track = 0;
      errors = 0;
      foreach (sused[i]) sused[i] = 0;
    endfunction

    function bit above(logic [47:0] ta, logic [15:0] ca, logic [47:0] tb, logic [15:0] cb);
      return ta > tb || (ta == tb && ca < cb);
    endfunction

    function int lookup(logic [63:0] key, output int slot);
      logic [63:0] m;
      int home, i;
      m = key * HASH_MUL;
      home = m[63:32] % SEEN_N;
      slot = 0;
      for (int p = 0; p < PROBES; p++) begin
        i = (home + p) % SEEN_N;
        if (!sused[i]) begin
          slot = i;
          return 0;
        end
        if (skey[i] == key) begin
          slot = i;
          return 1;
        end
      end
      return -1;
    endfunction

    function void place(item_t it, int lim);
      int pos;
      pos = size;
      while (pos > 0 && above(it.target_value, it.leader_card, kt[pos-1], kc[pos-1])) pos--;
      if (size >= KEEP_N) begin
        if (pos >= KEEP_N) return;
        size = KEEP_N - 1;
      end
      for (int i = size; i > pos; i--) begin
        kt[i] = kt[i-1]; kc[i] = kc[i-1]; ks[i] = ks[i-1];
        kl[i] = kl[i-1]; kp[i] = kp[i-1];
      end
      kt[pos] = it.target_value; kc[pos] = it.leader_card; ks[pos] = it.cand_score;
      kl[pos] = it.cand_live; kp[pos] = it.cand_power;
      size++;
      if (size > lim) size = lim;
    endfunction

    function void note_item(item_t it);
      result_t r;
      int lim, slot, f, w, ri;
      logic [63:0] k;
      r = '0;
      lim = limit_reg;
      if (lim < 1) lim = 1;
      if (lim > KEEP_N) lim = KEEP_N;
      if (it.req_type == REQ_READ || it.req_type == REQ_READ3) begin
        r.outcome = OUT_READ;
        ri = it.read_index;
        if (ri < size) begin
          k = key_of(ks[ri], kl[ri], kp[ri], kc[ri]);
          if (lookup(k, slot) == 1) r.sources = ssrc[slot];
          r.entry_valid = 1;
          r.entry_target = kt[ri]; r.entry_card = kc[ri]; r.entry_score = ks[ri];
          r.entry_live = kl[ri]; r.entry_power = kp[ri];
        end
      end else if (size >= lim &&
                   above(kt[size-1], kc[size-1], it.target_value, it.leader_card)) begin
        r.outcome = OUT_BELOW;
      end else begin
        k = key_of(it.cand_score, it.cand_live, it.cand_power, it.leader_card);
        f = lookup(k, slot);
        if (f < 0) r.outcome = OUT_FULL;
        else if (f == 1) begin
          r.outcome = OUT_DUP;
          if (it.req_type == REQ_OFFER || track) ssrc[slot] |= it.algo_mask;
          r.sources = ssrc[slot];
        end else if (it.req_type == REQ_PROBE) r.outcome = OUT_PROBENEW;
        else begin
          r.outcome = OUT_INSERTED;
          sused[slot] = 1; skey[slot] = k; ssrc[slot] = it.algo_mask;
          r.sources = it.algo_mask;
          place(it, lim);
          if (size >= lim && size > 0) begin
            w = size - 1;
            if (kt[w] > tfloor) tfloor = kt[w];
            if (kp[w] > pfloor) pfloor = kp[w];
          end
        end
      end
      r.count_kept = size[6:0];
      r.floor_value = tfloor;
      r.floor_strength = pfloor;
      pending = {pending, r};
    endfunction

    function void check_result(result_t a);
      result_t e;
      logic [63:0] ev[11], av[11];
      string nm[11];
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %h", a);
        return;
      end
      e = pending.pop_front();
      nm = '{"outcome", "count_kept", "floor_value", "floor_strength", "sources",
             "entry_valid", "entry_target", "entry_card", "entry_score", "entry_live",
             "entry_power"};
      ev = '{e.outcome, e.count_kept, e.floor_value, e.floor_strength, e.sources,
             e.entry_valid, e.entry_target, e.entry_card, e.entry_score, e.entry_live,
             e.entry_power};
      av = '{a.outcome, a.count_kept, a.floor_value, a.floor_strength, a.sources,
             a.entry_valid, a.entry_target, a.entry_card, a.entry_score, a.entry_live,
             a.entry_power};
      foreach (ev[i]) if (ev[i] !== av[i]) begin
        errors++;
        if (errors <= 10) $display("mismatch %s: expected %h got %h", nm[i], ev[i], av[i]);
      end
    endfunction
  endclass

  logic clk, rst, cfg_we, cfg_index;
  logic [6:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  item_t   drv;
  result_t res;
  keeper_scoreboard sb;
  int send_pct, stall_pct, idle_cycles;
  item_t pool[$];

  top_k_dedup_keeper u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(drv.req_type), .target_value(drv.target_value), .leader_card(drv.leader_card),
    .cand_score(drv.cand_score), .cand_live(drv.cand_live), .cand_power(drv.cand_power),
    .algo_mask(drv.algo_mask), .read_index(drv.read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .outcome(res.outcome), .count_kept(res.count_kept), .floor_value(res.floor_value),
    .floor_strength(res.floor_strength), .sources(res.sources),
    .entry_valid(res.entry_valid), .entry_target(res.entry_target),
    .entry_card(res.entry_card), .entry_score(res.entry_score),
    .entry_live(res.entry_live), .entry_power(res.entry_power)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    if (!rst && out_valid && !out_stall) sb.check_result(res);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == CFG_KEEP_LIMIT) sb.limit_reg = val;
    else sb.track = val[0];
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send(item_t it);
    if (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
    drv <= it;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    if (it.req_type == REQ_OFFER && pool.size() < 300) pool = {pool, it};
  endtask

  function automatic item_t mk(req_t rq, logic [47:0] t, logic [15:0] c, logic [31:0] s,
                               logic [31:0] l, logic [23:0] p, logic [31:0] m,
                               logic [5:0] ri);
    item_t it;
    it.req_type = rq; it.target_value = t; it.leader_card = c; it.cand_score = s;
    it.cand_live = l; it.cand_power = p; it.algo_mask = m; it.read_index = ri;
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.target_value = ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom}) :
                      48'($urandom_range(0, 40)) << 16;
    it.leader_card = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    it.cand_score = $urandom;
    it.cand_live = $urandom;
    it.cand_power = 24'($urandom);
    it.algo_mask = 32'd1 << $urandom_range(0, 31);
    if ($urandom_range(0, 7) == 0) it.algo_mask = $urandom;
    it.read_index = ($urandom_range(0, 3) == 0) ? 6'($urandom) :
                    6'($urandom_range(0, (sb.size > 0) ? sb.size - 1 : 0));
    it.req_type = REQ_OFFER;
    if (sel >= 55 && sel < 72 && pool.size() > 0) begin
      it = pool[$urandom_range(0, pool.size() - 1)];
      it.algo_mask = 32'd1 << $urandom_range(0, 31);
      it.req_type = ($urandom_range(0, 1) == 0) ? REQ_OFFER : REQ_PROBE;
    end else if (sel >= 72 && sel < 82) it.req_type = REQ_PROBE;
    else if (sel >= 82 && sel < 97) it.req_type = REQ_READ;
    else if (sel >= 97) it.req_type = REQ_READ3;
    return it;
  endfunction

  initial begin
    int same[$];
    int home0, n;
    logic [63:0] m;
    int pct_s[4] = '{0, 51, 0, 38};
    int pct_r[4] = '{0, 0, 51, 38};
    int lims[8] = '{64, 1, 0, 127, 5, 64, 17, 2};
    sb = new();
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; out_stall = 0; drv = '0;
    send_pct = 0; stall_pct = 0; idle_cycles = 0;
    m = key_of(32'h1234, 32'h55, 24'h77, 16'd0) * HASH_MUL;
    home0 = m[63:32] % SEEN_N;
    for (int c = 1; c < 65536 && same.size() < 8; c++) begin
      m = key_of(32'h1234, 32'h55, 24'h77, 16'(c)) * HASH_MUL;
      if (m[63:32] % SEEN_N == home0) same = {same, c};
    end
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // colliding keys fill the probe window, the ninth finds no room
    send(mk(REQ_OFFER, 48'h10000, 16'd0, 32'h1234, 32'h55, 24'h77, 32'h1, 6'd0));
    foreach (same[i])
      send(mk(REQ_OFFER, 48'h10000, 16'(same[i]), 32'h1234, 32'h55, 24'h77, 32'h2, 6'd0));
    send(mk(REQ_PROBE, 48'h10000, 16'(same[7]), 32'h1234, 32'h55, 24'h77, 32'h4, 6'd0));
    send(mk(REQ_OFFER, '1, '1, '1, '1, '1, '1, 6'd0));
    send(mk(REQ_OFFER, '0, '0, '0, '0, '0, '0, 6'd0));
    send(mk(REQ_OFFER, '1, '1, '1, '1, '1, 32'h8000_0000, 6'd0));
    send(mk(REQ_PROBE, '1, '1, '1, '1, '1, 32'h0000_0100, 6'd0));
    send(mk(REQ_PROBE, 48'h5, 16'h9, 32'h9, 32'h9, 24'h9, 32'h1, 6'd0));
    send(mk(REQ_READ, '0, '0, '0, '0, '0, '0, 6'd0));
    send(mk(REQ_READ3, '0, '0, '0, '0, '0, '0, 6'd1));
    send(mk(REQ_READ, '0, '0, '0, '0, '0, '0, 6'd63));
    drain();
    write_reg(CFG_TRACK, 7'd1);
    send(mk(REQ_PROBE, '1, '1, '1, '1, '1, 32'h0000_0200, 6'd0));
    send(mk(REQ_READ, '0, '0, '0, '0, '0, '0, 6'd0));
    drain();
    write_reg(CFG_KEEP_LIMIT, 7'd2);
    send(mk(REQ_OFFER, 48'h10000, 16'd3, 32'h77, 32'h1, 24'h1, 32'h1, 6'd0));
    send(mk(REQ_OFFER, 48'h10000, 16'd3, 32'h78, 32'h1, 24'h1, 32'h1, 6'd0));
    send(mk(REQ_READ, '0, '0, '0, '0, '0, '0, 6'd1));

    for (int ph = 0; ph < 16; ph++) begin
      drain();
      write_reg(CFG_KEEP_LIMIT, (ph < 8) ? 7'(lims[ph]) : 7'($urandom_range(0, 127)));
      write_reg(CFG_TRACK, 7'(ph & 1));
      send_pct = pct_s[ph % 4];
      stall_pct = pct_r[ph % 4];
      n = 88;
      for (int i = 0; i < n; i++) send(rand_item());
      in_valid <= 0;
      @(posedge clk);
    end
    send_pct = 0;
    stall_pct = 0;
    drain();
    if (sb.pending.size() != 0) sb.errors++;
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
